// ===== sv/ptc_pkg.sv =====
package ptc_pkg;

	localparam int NUM_CHANNELS = 1024;
	localparam int TIME_BITS    = 48;
	localparam int SNR_BITS     = 16;

	localparam int CH_BITS      = 10;
	localparam int CHISQ_BITS   = 16;
	localparam int MAG_BITS     = 2 * SNR_BITS;
	localparam int ADDR_BITS    = $clog2(NUM_CHANNELS);

	localparam int THRESH_BITS  = 32;
	localparam int GAP_BITS     = 20;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1982464);
	localparam logic [GAP_BITS-1:0]    GAP_RESET    = GAP_BITS'(41);

	// register index, taken from paddr[2]
	localparam logic REG_THRESH = 1'b0;
	localparam logic REG_GAP    = 1'b1;

	// segment generation tag stored with each peak
	localparam int EPOCH_BITS = 4;
	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic                   valid;
		logic [EPOCH_BITS-1:0]  tag;
		logic [MAG_BITS-1:0]    mag;
		logic [TIME_BITS-1:0]   pk_time;
		logic [SNR_BITS-1:0]    re;
		logic [SNR_BITS-1:0]    im;
		logic [CHISQ_BITS-1:0]  chisq;
	} peak_t;

	typedef struct packed {
		logic [CH_BITS-1:0]     channel;
		logic [TIME_BITS-1:0]   ev_time;
		logic [SNR_BITS-1:0]    re;
		logic [SNR_BITS-1:0]    im;
		logic [CHISQ_BITS-1:0]  chisq;
		logic [MAG_BITS-1:0]    mag;
	} event_t;

endpackage

// ===== sv/ptc_sample_if.sv =====
interface ptc_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic [ptc_pkg::CH_BITS-1:0]           channel;
	logic [ptc_pkg::TIME_BITS-1:0]         sample_time;
	logic signed [ptc_pkg::SNR_BITS-1:0]   snr_re;
	logic signed [ptc_pkg::SNR_BITS-1:0]   snr_im;
	logic [ptc_pkg::CHISQ_BITS-1:0]        chisq;

	modport source (output valid, kind, channel, sample_time, snr_re, snr_im, chisq,
		input ready);
	modport sink (input valid, kind, channel, sample_time, snr_re, snr_im, chisq,
		output ready);
endinterface

// ===== sv/ptc_event_if.sv =====
interface ptc_event_if;
	logic                                  valid;
	logic                                  ready;
	logic [ptc_pkg::CH_BITS-1:0]           event_channel;
	logic [ptc_pkg::TIME_BITS-1:0]         event_time;
	logic signed [ptc_pkg::SNR_BITS-1:0]   event_re;
	logic signed [ptc_pkg::SNR_BITS-1:0]   event_im;
	logic [ptc_pkg::CHISQ_BITS-1:0]        event_chisq;
	logic [ptc_pkg::MAG_BITS-1:0]          event_mag_sq;

	modport source (output valid, event_channel, event_time, event_re, event_im,
		event_chisq, event_mag_sq, input ready);
	modport sink (input valid, event_channel, event_time, event_re, event_im,
		event_chisq, event_mag_sq, output ready);
endinterface

// ===== sv/per_channel_trigger_clusterer_core.sv =====
// channel   dir  handshake        word
// samples   in   valid/ready      kind, channel, sample_time, snr_re, snr_im, chisq
// events    out  valid/ready      event_channel, event_time, event_re, event_im,
//                                 event_chisq, event_mag_sq
// apb       cfg  psel/penable     reg 0 snr_thresh_sq @0x0, reg 1 max_gap_samples @0x4
//
// One word per ready cycle. Two stages: squares at accept, read of the per-channel
// memories in stage 1, decision and write-back in stage 2, with a one-word bypass.
// After reset a clearing pass over all 1024 channels runs with samples.ready low.
// Segment start bumps a 4-bit tag; every 16th one runs a valid-clear pass of peak_mem.
// Events go through a 4-word FIFO; ready also drops when it could overflow.
module per_channel_trigger_clusterer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	ptc_sample_if.sink                        samples,
	ptc_event_if.source                       events,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ptc_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [ptc_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [ptc_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready
);
	import ptc_pkg::*;

	// configuration
	logic [THRESH_BITS-1:0] thresh_q;
	logic [GAP_BITS-1:0]    gap_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			gap_q    <= GAP_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_THRESH: thresh_q <= pwdata[THRESH_BITS-1:0];
				REG_GAP:    gap_q    <= pwdata[GAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THRESH: prdata = APB_DATA_BITS'(thresh_q);
			REG_GAP:    prdata = APB_DATA_BITS'(gap_q);
			default:    prdata = '0;
		endcase
	end

	// memories
	logic [TIME_BITS-1:0] time_mem [NUM_CHANNELS];
	peak_t                peak_mem [NUM_CHANNELS];

	// clearing pass
	logic                 pass_q;
	logic                 pass_time_q;
	logic [ADDR_BITS-1:0] pass_addr_q;
	logic [EPOCH_BITS-1:0] epoch_q;

	// stage 1
	logic                  s1_v;
	logic                  kind_s1;
	logic                  inrange_s1;
	logic [CH_BITS-1:0]    ch_s1;
	logic [TIME_BITS-1:0]  t_s1;
	logic [SNR_BITS-1:0]   re_s1;
	logic [SNR_BITS-1:0]   im_s1;
	logic [CHISQ_BITS-1:0] chisq_s1;
	logic [MAG_BITS-1:0]   sq_re_s1;
	logic [MAG_BITS-1:0]   sq_im_s1;
	logic [MAG_BITS-1:0]   mag_s1;
	logic                  act_s1;

	// stage 2
	logic                  s2_v;
	logic [CH_BITS-1:0]    ch_s2;
	logic [TIME_BITS-1:0]  t_s2;
	logic [SNR_BITS-1:0]   re_s2;
	logic [SNR_BITS-1:0]   im_s2;
	logic [CHISQ_BITS-1:0] chisq_s2;
	logic [MAG_BITS-1:0]   mag_s2;
	logic [TIME_BITS-1:0]  rd_time_s2;
	peak_t                 rd_peak_s2;
	logic                  fwd_s2;
	logic [TIME_BITS-1:0]  fwd_time_s2;
	peak_t                 fwd_peak_s2;

	logic [TIME_BITS-1:0]  prior_time;
	peak_t                 held;
	logic                  held_v;
	logic [MAG_BITS-1:0]   held_mag;
	logic [TIME_BITS-1:0]  gap_ext;
	logic                  new_evt;
	logic                  take;
	logic                  wr_en;
	logic                  emit;
	peak_t                 new_peak;
	event_t                new_ev;

	// input side
	logic                  accept;
	logic                  wrap_hold;
	logic [SNR_BITS-1:0]   abs_re;
	logic [SNR_BITS-1:0]   abs_im;
	logic [FIFO_CNT_BITS:0] credit_sum;

	// output fifo
	event_t                   fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;
	logic                     pop;
	event_t                   head;

	assign wrap_hold  = s1_v && kind_s1 && (epoch_q == EPOCH_MAX);
	assign credit_sum = (FIFO_CNT_BITS+1)'(cnt_q) + (FIFO_CNT_BITS+1)'(s1_v)
		+ (FIFO_CNT_BITS+1)'(s2_v);
	assign samples.ready = !pass_q && !wrap_hold
		&& (credit_sum < (FIFO_CNT_BITS+1)'(FIFO_DEPTH));
	assign accept = samples.valid && samples.ready;

	always_comb begin
		abs_re = samples.snr_re[SNR_BITS-1] ? SNR_BITS'(~samples.snr_re + 1'b1)
			: samples.snr_re;
		abs_im = samples.snr_im[SNR_BITS-1] ? SNR_BITS'(~samples.snr_im + 1'b1)
			: samples.snr_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= samples.kind;
			inrange_s1 <= ({1'b0, samples.channel} < (CH_BITS+1)'(NUM_CHANNELS));
			ch_s1      <= samples.channel;
			t_s1       <= samples.sample_time;
			re_s1      <= samples.snr_re;
			im_s1      <= samples.snr_im;
			chisq_s1   <= samples.chisq;
			sq_re_s1   <= MAG_BITS'(abs_re) * MAG_BITS'(abs_re);
			sq_im_s1   <= MAG_BITS'(abs_im) * MAG_BITS'(abs_im);
		end
	end

	assign mag_s1 = sq_re_s1 + sq_im_s1;
	assign act_s1 = s1_v && !kind_s1 && inrange_s1 && (mag_s1 >= thresh_q);

	// epoch and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q      <= 1'b1;
			pass_time_q <= 1'b1;
			pass_addr_q <= '0;
			epoch_q     <= '0;
		end else begin
			if (pass_q) begin
				pass_addr_q <= pass_addr_q + 1'b1;
				if (pass_addr_q == ADDR_BITS'(NUM_CHANNELS - 1)) begin
					pass_q      <= 1'b0;
					pass_time_q <= 1'b0;
				end
			end
			if (s1_v && kind_s1) begin
				epoch_q <= epoch_q + 1'b1;
				if (epoch_q == EPOCH_MAX) begin
					pass_q      <= 1'b1;
					pass_addr_q <= '0;
				end
			end
		end
	end

	// stage 2 registers, memory read, bypass of the write in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v   <= 1'b0;
			fwd_s2 <= 1'b0;
		end else begin
			s2_v   <= act_s1;
			fwd_s2 <= wr_en && (ch_s2 == ch_s1);
		end
	end

	always_ff @(posedge clk) begin
		ch_s2       <= ch_s1;
		t_s2        <= t_s1;
		re_s2       <= re_s1;
		im_s2       <= im_s1;
		chisq_s2    <= chisq_s1;
		mag_s2      <= mag_s1;
		fwd_time_s2 <= t_s2;
		fwd_peak_s2 <= new_peak;
		rd_time_s2  <= time_mem[ch_s1[ADDR_BITS-1:0]];
		rd_peak_s2  <= peak_mem[ch_s1[ADDR_BITS-1:0]];
	end

	always_comb begin
		prior_time = fwd_s2 ? fwd_time_s2 : rd_time_s2;
		held      = fwd_s2 ? fwd_peak_s2 : rd_peak_s2;
		held_v    = held.valid && (held.tag == epoch_q);
		held_mag  = held_v ? held.mag : '0;
		gap_ext   = TIME_BITS'(gap_q);
		new_evt   = (t_s2 > prior_time) && ((t_s2 - prior_time) > gap_ext);
		take      = new_evt || (mag_s2 > held_mag);
		wr_en     = s2_v;
		emit      = s2_v && new_evt && held_v;

		if (take) begin
			new_peak = '{valid: (mag_s2 != '0), tag: epoch_q, mag: mag_s2,
				pk_time: t_s2, re: re_s2, im: im_s2, chisq: chisq_s2};
		end else begin
			new_peak       = held;
			new_peak.valid = held_v;
			new_peak.tag   = epoch_q;
		end

		new_ev = '{channel: ch_s2, ev_time: held.pk_time, re: held.re, im: held.im,
			chisq: held.chisq, mag: held.mag};
	end

	always_ff @(posedge clk) begin
		if (pass_q) begin
			peak_mem[pass_addr_q] <= '0;
			if (pass_time_q) begin
				time_mem[pass_addr_q] <= '0;
			end
		end else if (wr_en) begin
			peak_mem[ch_s2[ADDR_BITS-1:0]] <= new_peak;
			time_mem[ch_s2[ADDR_BITS-1:0]] <= t_s2;
		end
	end

	// output fifo
	assign pop  = events.valid && events.ready;
	assign head = fifo_q[rd_ptr_q];

	assign events.valid         = (cnt_q != '0);
	assign events.event_channel = head.channel;
	assign events.event_time    = head.ev_time;
	assign events.event_re      = head.re;
	assign events.event_im      = head.im;
	assign events.event_chisq   = head.chisq;
	assign events.event_mag_sq  = head.mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (emit) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CNT_BITS'(emit) - FIFO_CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			fifo_q[wr_ptr_q] <= new_ev;
		end
	end

	a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q |-> !samples.ready)
		else $error("sample taken during clearing pass");

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("event fifo overflow");

	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s2 |-> $past(wr_en))
		else $error("bypass without a write in flight");

	a_wrap_pass: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_hold |=> pass_q)
		else $error("tag wrap without clearing pass");

endmodule
